>>> src/cstavg_pkg.sv
// Shared constants and types for the channel status table with mean C/No.
package cstavg_pkg;

   localparam int CHANNELS_DEF = 12;
   localparam int CNT_W_DEF    = $clog2(CHANNELS_DEF + 1);
   localparam int SUM_W_DEF    = 16 + CNT_W_DEF;

   localparam logic [7:0] LOCKED_STATE = 8'hbf;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV,
      ST_WAIT,
      ST_RESP
   } state_type;

endpackage

>>> src/cstavg_div.sv
// Restoring serial divider, one quotient bit per cycle.
module cstavg_div #(
   parameter int DIVIDEND_W = cstavg_pkg::SUM_W_DEF,
   parameter int DIVISOR_W  = cstavg_pkg::CNT_W_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   import cstavg_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_sub;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits      = rem_shift >= {1'b0, divisor};
      rem_sub   = rem_shift - {1'b0, divisor};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits hold it
         rem_in  = fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/channel_status_table_avg_core.sv
// Channel status table with addressed read/write and mean C/No over locked channels.
//
// One request word (read or write of one channel entry) yields one response word.
// The response leaves once the request is accepted, any write done, the table scanned and
// the mean divided; when no channel is locked the divide is skipped. The next request is
// taken in the cycle after the response leaves, and a stalled response holds the block.
// The table sits in a memory with one read port, scanned one entry per cycle to build
// the locked sum and count, and the mean comes from a serial divider producing one
// quotient bit per cycle. The table reads as zero after reset through per-entry valid
// bits. A channel at or beyond CHANNELS leaves the table alone, returns zero entry
// fields and raises bad_channel.
module channel_status_table_avg_core #(
   parameter int CHANNELS = cstavg_pkg::CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // channel[7:0], prn[15:8], track_state[23:16], cno[39:24]
   input  logic [39:0] req_tdata,
   // func[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // svid[7:0], chan_status[15:8], chan_cno[31:16], average_cno[47:32],
   // locked_count[51:48], zero[55:52]
   output logic [55:0] rsp_tdata,
   // bad_channel[0]
   output logic [0:0]  rsp_tuser
);
   import cstavg_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int SUM_W = 16 + CNT_W;

   state_type state_ff, state_in;

   logic [31:0]      mem_ff [CHANNELS];
   logic             valid_ff [CHANNELS];

   logic             func_ff;
   logic [7:0]       channel_ff;
   logic [31:0]      wr_entry_ff;
   logic             bad_ff;
   logic [IDX_W-1:0] idx;

   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] rd_tag_ff;
   logic             rd_pend_ff, rd_pend_in;
   logic [31:0]      rd_data_ff;
   logic             rd_ok_ff;

   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] count_ff;
   logic [31:0]      entry_ff;
   logic [15:0]      avg_ff;

   logic             div_start;
   logic             div_done;
   logic [SUM_W-1:0] div_quo;

   logic             accept;
   logic             do_write;
   logic             locked_hit;

   assign accept     = req_tvalid && req_tready;
   assign idx        = channel_ff[IDX_W-1:0];
   assign do_write   = (state_ff == ST_WRITE) && (func_ff == FUNC_WRITE) && !bad_ff;
   assign locked_hit = rd_pend_ff && rd_ok_ff && (rd_data_ff[23:16] == LOCKED_STATE);

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      rd_pend_in = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            scan_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_pend_in = 1'b1;
            scan_in    = scan_ff + IDX_W'(1);
            if (scan_ff == IDX_W'(CHANNELS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // no locked channel: mean is zero, skip the divide
            if (count_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         if (do_write) begin
            valid_ff[idx] <= 1'b1;
         end
      end
   end

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[idx] <= wr_entry_ff;
      end
      rd_data_ff <= mem_ff[scan_ff];
      rd_ok_ff   <= valid_ff[scan_ff];
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      rd_tag_ff <= scan_ff;
      if (accept) begin
         func_ff     <= req_tuser[0];
         channel_ff  <= req_tdata[7:0];
         wr_entry_ff <= {req_tdata[15:8], req_tdata[23:16], req_tdata[39:24]};
         bad_ff      <= req_tdata[7:0] >= 8'(CHANNELS);
      end
      if (state_ff == ST_WRITE) begin
         sum_ff   <= '0;
         count_ff <= '0;
         entry_ff <= '0;
      end else if (rd_pend_ff) begin
         if (locked_hit) begin
            sum_ff   <= sum_ff + SUM_W'(rd_data_ff[15:0]);
            count_ff <= count_ff + CNT_W'(1);
         end
         if (!bad_ff && (rd_tag_ff == idx)) begin
            entry_ff <= rd_ok_ff ? rd_data_ff : 32'h0;
         end
      end
      if (state_ff == ST_DIV) begin
         avg_ff <= '0;
      end else if ((state_ff == ST_WAIT) && div_done) begin
         avg_ff <= div_quo[15:0];
      end
   end

   cstavg_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_tdata = {4'h0, 4'(count_ff), avg_ff, entry_ff[15:0], entry_ff[23:16],
                       entry_ff[31:24]};
   assign rsp_tuser = bad_ff;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the channel status table with mean C/No over locked channels.
module tb_top;
   import cstavg_pkg::*;

   localparam int NUM_CHANNELS = CHANNELS_DEF;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 310;
   localparam int PHASES       = 5;
   localparam int SETTLE       = 60;

   // bad_channel, zero pad, locked_count, average_cno, chan_cno, chan_status, svid
   typedef struct packed {
      logic        bad;
      logic [3:0]  pad;
      logic [3:0]  locked;
      logic [15:0] avg_cno;
      logic [15:0] cno;
      logic [7:0]  status;
      logic [7:0]  svid;
   } status_word_type;

   class status_scoreboard_type;
      logic [31:0]     entries [NUM_CHANNELS];
      status_word_type pending_status [$];
      int              errors;

      function new();
         foreach (entries[i]) entries[i] = '0;
         errors = 0;
      endfunction

      function int outstanding();
         return pending_status.size();
      endfunction

      // Apply one accepted word to the shadow table and queue its response word.
      function void note_request(logic func, logic [7:0] chan, logic [7:0] prn,
                                 logic [7:0] st, logic [15:0] cno);
         status_word_type w;
         int unsigned     sum;
         int unsigned     cnt;
         int unsigned     mean;
         bit              bad;
         bad  = chan >= NUM_CHANNELS;
         w    = '0;
         sum  = 0;
         cnt  = 0;
         mean = 0;
         if (!bad) begin
            if (func == FUNC_WRITE)
               entries[chan] = {prn, st, cno};
            w.svid   = entries[chan][31:24];
            w.status = entries[chan][23:16];
            w.cno    = entries[chan][15:0];
         end
         foreach (entries[i]) begin
            if (entries[i][23:16] == LOCKED_STATE) begin
               sum += entries[i][15:0];
               cnt++;
            end
         end
         if (cnt != 0)
            mean = sum / cnt;
         w.avg_cno = mean[15:0];
         w.locked  = cnt[3:0];
         w.bad     = bad;
         pending_status.push_back(w);
      endfunction

      function void check_response(status_word_type got);
         status_word_type want;
         if (pending_status.size() == 0) begin
            if (errors < 10)
               $display("unexpected response %h with nothing pending", got);
            errors++;
            return;
         end
         want = pending_status.pop_front();
         if (got.svid != want.svid || got.status != want.status || got.cno != want.cno ||
             got.avg_cno != want.avg_cno || got.locked != want.locked ||
             got.pad != want.pad || got.bad != want.bad) begin
            if (errors < 10)
               $display({"mismatch: svid %h/%h status %h/%h cno %h/%h avg %h/%h",
                         " locked %0d/%0d pad %h/%h bad %b/%b (exp/act)"},
                        want.svid, got.svid, want.status, got.status, want.cno, got.cno,
                        want.avg_cno, got.avg_cno, want.locked, got.locked,
                        want.pad, got.pad, want.bad, got.bad);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   status_scoreboard_type sb;
   bit                    calm_period;
   int                    cycles;

   channel_status_table_avg_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      cycles = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Both channels are sampled at the edge, so notes land before any check.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser[0], req_tdata[7:0], req_tdata[15:8],
                            req_tdata[23:16], req_tdata[39:24]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response({rsp_tuser, rsp_tdata});
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Result side: hold ready for a while, then drop it for a random gap outside calm phases.
   initial begin
      int gap;
      int hold;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         hold = $urandom_range(1, 20);
         repeat (hold) @(posedge clock);
         gap = calm_period ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic func, input logic [7:0] chan,
                               input logic [7:0] prn, input logic [7:0] st,
                               input logic [15:0] cno);
      int gap;
      req_tdata  <= {cno, st, prn, chan};
      req_tuser  <= func;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      gap = calm_period ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic send_random();
      logic        func;
      logic [7:0]  chan;
      logic [7:0]  st;
      logic [15:0] cno;
      int          r;
      func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
      r = $urandom_range(0, 9);
      if (r < 8)
         chan = 8'($urandom_range(0, NUM_CHANNELS - 1));
      else if (r == 8)
         chan = 8'($urandom_range(NUM_CHANNELS, 255));
      else
         chan = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 9);
      if (r < 5)
         st = LOCKED_STATE;
      else if (r == 5)
         st = LOCKED_STATE ^ (8'h01 << $urandom_range(0, 7));
      else if (r == 6)
         st = 8'h00;
      else
         st = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 9);
      if (r == 0)
         cno = 16'h0000;
      else if (r == 1)
         cno = 16'hffff;
      else if (r == 2)
         cno = 16'($urandom_range(0, 15));
      else
         cno = 16'($urandom_range(0, 65535));
      send_request(func, chan, 8'($urandom_range(0, 255)), st, cno);
   endtask

   initial begin
      sb          = new();
      calm_period = 1'b0;
      reset       = 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_READ;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Cleared table, edge channels and rejected indexes.
      send_request(FUNC_READ, 8'd0, 8'hff, 8'hff, 16'hffff);
      send_request(FUNC_READ, 8'(NUM_CHANNELS - 1), 8'h00, 8'h00, 16'h0000);
      send_request(FUNC_READ, 8'(NUM_CHANNELS), 8'h5a, LOCKED_STATE, 16'h1234);
      send_request(FUNC_READ, 8'd255, 8'hff, 8'hff, 16'hffff);
      send_request(FUNC_WRITE, 8'(NUM_CHANNELS), 8'hff, LOCKED_STATE, 16'hffff);
      send_request(FUNC_WRITE, 8'd255, 8'hff, LOCKED_STATE, 16'hffff);
      // Lock every channel at full-scale C/No to reach the widest sum.
      for (int i = 0; i < NUM_CHANNELS; i++)
         send_request(FUNC_WRITE, 8'(i), 8'hff ^ 8'(i), LOCKED_STATE, 16'hffff);
      // States one bit away from locked drop out of the mean.
      send_request(FUNC_WRITE, 8'd4, 8'h11, LOCKED_STATE ^ 8'h01, 16'h0000);
      send_request(FUNC_WRITE, 8'd7, 8'h22, LOCKED_STATE ^ 8'h80, 16'h8000);
      send_request(FUNC_WRITE, 8'd0, 8'h00, LOCKED_STATE, 16'h0000);
      send_request(FUNC_READ, 8'd0, 8'h00, 8'h00, 16'h0000);
      send_request(FUNC_READ, 8'd4, 8'h00, 8'h00, 16'h0000);
      send_request(FUNC_WRITE, 8'(NUM_CHANNELS - 1), 8'h00, 8'h00, 16'h0000);
      send_request(FUNC_READ, 8'd128, 8'h00, 8'h00, 16'h0000);
      req_tvalid <= 1'b0;
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         calm_period = (p == 1 || p == 3);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random();
         req_tvalid <= 1'b0;
         // hold off the next phase until every response is back
         wait_drained();
      end

      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
